@@ rtl/f32s_pkg.sv @@
// Shared types, constants and helpers for the FAT32 frame sector-run sequencer.
package f32s_pkg;

  // Frame geometry
  localparam int unsigned FRAME_SECTORS = 600;
  localparam int unsigned SECT_W        = 22;   // frame_in_file * FRAME_SECTORS fits here
  localparam int unsigned SLEFT_W       = 10;

  // FAT32 entry handling
  localparam logic [27:0] CHAIN_END = 28'hFFFFFF8;

  // Configuration register indexes
  localparam logic [1:0] REG_SPC       = 2'd0;
  localparam logic [1:0] REG_FAT_START = 2'd1;
  localparam logic [1:0] REG_DATA_START = 2'd2;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // Output kinds
  localparam logic [1:0] KIND_REQ = 2'd0;
  localparam logic [1:0] KIND_RUN = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Error codes
  localparam logic ERR_SKIP = 1'b0;
  localparam logic ERR_READ = 1'b1;

  // Fetch phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        carry;   // for a subtract: set when a >= b
  } alu_rsp_t;

  // Cluster size as used: 0 acts as 1, above 128 acts as 128.
  function automatic logic [7:0] eff_spc(input logic [7:0] spc);
    logic [7:0] r;
    r = spc;
    if (spc == 8'd0) begin
      r = 8'd1;
    end else if (spc > 8'd128) begin
      r = 8'd128;
    end
    return r;
  endfunction

  function automatic logic cluster_ok(input logic [27:0] c);
    return (c >= 28'd2) && (c < CHAIN_END);
  endfunction

  // Sector offset of a frame within the file.
  function automatic logic [SECT_W-1:0] frame_sect(input logic [11:0] frame);
    logic [SECT_W-1:0] p;
    p = SECT_W'(frame) * SECT_W'(FRAME_SECTORS);
    return p;
  endfunction

endpackage

@@ rtl/fat32_frame_sector_run_sequencer.sv @@
// Top level: frame request to FAT chain walk and data sector runs.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready    | tuser: operation; tdata: first_cluster,
//            |     |                                  |   frame_in_file, fat_entry
//  m_axis    | out | m_axis_tvalid / m_axis_tready    | tuser: kind; tlast: last; tdata:
//            |     |                                  |   sector_address, sector_count,
//            |     |                                  |   entry_slot, error_code
//  cfg       | in  | cfg_we (no wait)                 | cfg_index, cfg_data
//
// Sequence: a start item runs 22 restoring division steps (frame sector / cluster size)
// on the shared adder plus a decision step (S_CHK); its run result then passes through
// cluster-2, 8 shift-add multiply steps, two adds and the output load, and a FAT request
// or an error goes from S_CHK to the output load. A reply gives an error, a FAT request,
// or a run followed by its follow-up request. Wide arithmetic goes through the one
// 32-bit adder.
// s_axis_tready is high only while the sequencer is idle; a result waits in the
// output register while the next item is taken, and while that register stays
// full the next result waits in S_OUT. Reset clears control state and
// the configuration registers (cluster size 8, both sector bases 0).
module fat32_frame_sector_run_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [27:0] first_cluster, [39:28] frame_in_file,
                                      // [71:40] fat_entry
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] sector_address, [39:32] sector_count,
                                      // [46:40] entry_slot, [47] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned SW = f32s_pkg::SECT_W;
  localparam int unsigned LW = f32s_pkg::SLEFT_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,  // one quotient bit per cycle
    S_CHK  = 9'b000000100,  // decide skip or read after the division
    S_REQ  = 9'b000001000,  // FAT sector address for the current cluster
    S_RUN  = 9'b000010000,  // run checks, cluster - 2
    S_MUL  = 9'b000100000,  // (cluster - 2) * spc, shift-add
    S_ADDD = 9'b001000000,  // + data_start_sector
    S_ADDB = 9'b010000000,  // + sector offset, stage the run
    S_OUT  = 9'b100000000   // hand staged result to the output register
  } state_t;

  // configuration
  logic [7:0]  spc_reg;
  logic [31:0] fat_start;
  logic [31:0] data_start;
  logic [7:0]  spc_live;

  // fetch state
  state_t          state;
  state_t          after;
  logic [1:0]      phase;
  logic [27:0]     cluster;
  logic [6:0]      blk;
  logic [LW-1:0]   sleft;
  logic [SW-1:0]   skip;      // dividend, then quotient, then clusters left to skip
  logic [7:0]      rem;
  logic [4:0]      cnt;
  logic [7:0]      spc_use;   // divisor, then multiplier bits shifted out
  logic [31:0]     mcand;
  logic [31:0]     acc;
  logic [7:0]      nsec;

  // staged result
  logic [1:0]  res_kind;
  logic [31:0] res_addr;
  logic [7:0]  res_count;
  logic [6:0]  res_slot;
  logic        res_ecode;
  logic        res_last;

  // output register
  logic [1:0]  out_kind;
  logic [31:0] out_addr;
  logic [7:0]  out_count;
  logic [6:0]  out_slot;
  logic        out_ecode;
  logic        out_last;
  logic        out_valid;

  // input fields
  logic        in_op;
  logic [27:0] in_first;
  logic [11:0] in_frame;
  logic [27:0] in_entry;
  logic        in_acc;

  f32s_pkg::alu_req_t alu_req;
  f32s_pkg::alu_rsp_t alu_rsp;

  logic [8:0]  div_part;
  logic [7:0]  span;        // sectors from blk to end of cluster
  logic [7:0]  nsec_calc;

  assign in_op    = s_axis_tuser[0];
  assign in_first = s_axis_tdata[27:0];
  assign in_frame = s_axis_tdata[39:28];
  assign in_entry = s_axis_tdata[67:40];   // entry masked to 28 bits

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_ecode, out_slot, out_count, out_addr};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  assign spc_live = f32s_pkg::eff_spc(spc_reg);
  assign div_part = {rem, skip[SW-1]};
  assign span     = spc_live - {1'b0, blk};
  assign nsec_calc = ({2'b00, span} > sleft) ? sleft[7:0] : span;

  // operand selection for the shared adder
  always_comb begin
    alu_req.op = f32s_pkg::ALU_ADD;
    alu_req.a  = acc;
    alu_req.b  = mcand;
    case (state)
      S_DIV: begin
        alu_req.op = f32s_pkg::ALU_SUB;
        alu_req.a  = {23'd0, div_part};
        alu_req.b  = {24'd0, spc_use};
      end
      S_REQ: begin
        alu_req.a = fat_start;
        alu_req.b = {11'd0, cluster[27:7]};
      end
      S_RUN: begin
        alu_req.op = f32s_pkg::ALU_SUB;
        alu_req.a  = {4'd0, cluster};
        alu_req.b  = 32'd2;
      end
      S_ADDD: begin
        alu_req.b = data_start;
      end
      S_ADDB: begin
        alu_req.b = {25'd0, blk};
      end
      default: begin
        alu_req.a = acc;
      end
    endcase
  end

  f32s_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spc_reg    <= 8'd8;
      fat_start  <= 32'd0;
      data_start <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        f32s_pkg::REG_SPC:        spc_reg    <= cfg_data[7:0];
        f32s_pkg::REG_FAT_START:  fat_start  <= cfg_data;
        f32s_pkg::REG_DATA_START: data_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register: loads from the staged result when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || m_axis_tready)) begin
      out_kind  <= res_kind;
      out_addr  <= res_addr;
      out_count <= res_count;
      out_slot  <= res_slot;
      out_ecode <= res_ecode;
      out_last  <= res_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      after   <= S_IDLE;
      phase   <= f32s_pkg::PH_IDLE;
      cluster <= 28'd0;
      blk     <= 7'd0;
      sleft   <= '0;
      skip    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_op == f32s_pkg::OP_START) begin
              // a start always replaces any fetch in progress
              cluster <= in_first;
              skip    <= f32s_pkg::frame_sect(in_frame);
              rem     <= 8'd0;
              cnt     <= 5'(SW - 1);
              spc_use <= spc_live;
              sleft   <= LW'(f32s_pkg::FRAME_SECTORS);
              state   <= S_DIV;
            end else if (phase == f32s_pkg::PH_SKIP) begin
              if (!f32s_pkg::cluster_ok(in_entry)) begin
                res_kind  <= f32s_pkg::KIND_ERR;
                res_addr  <= 32'd0;
                res_count <= 8'd0;
                res_slot  <= 7'd0;
                res_ecode <= f32s_pkg::ERR_SKIP;
                res_last  <= 1'b1;
                phase     <= f32s_pkg::PH_IDLE;
                after     <= S_IDLE;
                state     <= S_OUT;
              end else begin
                cluster <= in_entry;
                skip    <= skip - 1'b1;
                state   <= (skip == SW'(1)) ? S_RUN : S_REQ;
                after   <= S_IDLE;
              end
            end else if (phase == f32s_pkg::PH_READ) begin
              if (!f32s_pkg::cluster_ok(in_entry)) begin
                res_kind  <= f32s_pkg::KIND_ERR;
                res_addr  <= 32'd0;
                res_count <= 8'd0;
                res_slot  <= 7'd0;
                res_ecode <= f32s_pkg::ERR_READ;
                res_last  <= 1'b1;
                phase     <= f32s_pkg::PH_IDLE;
                after     <= S_IDLE;
                state     <= S_OUT;
              end else begin
                cluster <= in_entry;
                state   <= S_RUN;
              end
            end
            // a reply while idle is dropped
          end
        end

        S_DIV: begin
          // restoring division: skip shifts out dividend bits and takes quotient bits
          if (alu_rsp.carry) begin
            rem <= alu_rsp.sum[7:0];
          end else begin
            rem <= div_part[7:0];
          end
          skip <= {skip[SW-2:0], alu_rsp.carry};
          cnt  <= cnt - 1'b1;
          if (cnt == 5'd0) begin
            state <= S_CHK;
          end
        end

        S_CHK: begin
          blk <= rem[6:0];
          if (skip == '0) begin
            state <= S_RUN;
          end else if (!f32s_pkg::cluster_ok(cluster)) begin
            res_kind  <= f32s_pkg::KIND_ERR;
            res_addr  <= 32'd0;
            res_count <= 8'd0;
            res_slot  <= 7'd0;
            res_ecode <= f32s_pkg::ERR_SKIP;
            res_last  <= 1'b1;
            phase     <= f32s_pkg::PH_IDLE;
            after     <= S_IDLE;
            state     <= S_OUT;
          end else begin
            phase <= f32s_pkg::PH_SKIP;
            after <= S_IDLE;
            state <= S_REQ;
          end
        end

        S_REQ: begin
          res_kind  <= f32s_pkg::KIND_REQ;
          res_addr  <= alu_rsp.sum;
          res_count <= 8'd0;
          res_slot  <= cluster[6:0];
          res_ecode <= 1'b0;
          res_last  <= 1'b0;
          state     <= S_OUT;
        end

        S_RUN: begin
          if (({1'b0, blk} >= spc_live) || !f32s_pkg::cluster_ok(cluster) ||
              (sleft == '0)) begin
            res_kind  <= f32s_pkg::KIND_ERR;
            res_addr  <= 32'd0;
            res_count <= 8'd0;
            res_slot  <= 7'd0;
            res_ecode <= f32s_pkg::ERR_READ;
            res_last  <= 1'b1;
            phase     <= f32s_pkg::PH_IDLE;
            after     <= S_IDLE;
            state     <= S_OUT;
          end else begin
            mcand   <= alu_rsp.sum;
            spc_use <= spc_live;
            nsec    <= nsec_calc;
            acc     <= 32'd0;
            cnt     <= 5'd0;
            state   <= S_MUL;
          end
        end

        S_MUL: begin
          if (spc_use[0]) begin
            acc <= alu_rsp.sum;
          end
          mcand   <= {mcand[30:0], 1'b0};
          spc_use <= {1'b0, spc_use[7:1]};
          cnt     <= cnt + 1'b1;
          if (cnt == 5'd7) begin
            state <= S_ADDD;
          end
        end

        S_ADDD: begin
          acc   <= alu_rsp.sum;
          state <= S_ADDB;
        end

        S_ADDB: begin
          res_kind  <= f32s_pkg::KIND_RUN;
          res_addr  <= alu_rsp.sum;
          res_count <= nsec;
          res_slot  <= 7'd0;
          res_ecode <= 1'b0;
          sleft     <= sleft - LW'(nsec);
          state     <= S_OUT;
          if (sleft == LW'(nsec)) begin
            // frame complete: no further FAT request
            res_last <= 1'b1;
            blk      <= blk + nsec[6:0];
            phase    <= f32s_pkg::PH_IDLE;
            after    <= S_IDLE;
          end else begin
            res_last <= 1'b0;
            blk      <= 7'd0;
            phase    <= f32s_pkg::PH_READ;
            after    <= S_REQ;
          end
        end

        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            state <= after;
            after <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/f32s_alu.sv @@
// Shared 32-bit add/subtract unit used by every arithmetic step of the sequencer.
module f32s_alu (
  input  f32s_pkg::alu_req_t req,
  output f32s_pkg::alu_rsp_t rsp
);

  logic [31:0] b_eff;
  logic [32:0] full;

  always_comb begin
    b_eff = (req.op == f32s_pkg::ALU_SUB) ? ~req.b : req.b;
    full  = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, (req.op == f32s_pkg::ALU_SUB)};
    rsp.sum   = full[31:0];
    rsp.carry = full[32];
  end

endmodule
